/* sv/ihexw_pkg.sv */
// Shared types, constants and helpers for the Intel HEX record writer.
// No dependencies; imported by every module of the block.
`default_nettype none

package ihexw_pkg;

	localparam int ADDR_BITS = 32;
	localparam logic [32:0] ADDR_MASK_W = (33'd1 << ADDR_BITS) - 33'd1;
	localparam logic [31:0] ADDR_MASK = ADDR_MASK_W[31:0];

	localparam logic [7:0] RECLEN_RESET = 8'h20;
	localparam logic [7:0] ADDR_REC_LEN = 8'h02;
	localparam logic [7:0] TYPE_ELA = 8'h04;
	localparam logic [15:0] LO16_LAST = 16'hFFFF;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_NL = 8'h0A;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [7:0] data_byte;
		logic [31:0] byte_address;
		logic [31:0] bytes_left;
		logic segment_start;
		logic file_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] text_char;
		logic last_char;
	} out_item_t;

	// One classified item: which parts of text it causes and their bytes.
	typedef struct packed {
		logic do_addr;
		logic [7:0] addr_hi;
		logic [7:0] addr_mid;
		logic [7:0] addr_sum;
		logic do_open;
		logic [7:0] rec_len;
		logic [7:0] lo_hi;
		logic [7:0] lo_lo;
		logic [7:0] data;
		logic do_close;
		logic [7:0] close_sum;
		logic do_eof;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic [QCNT_W-1:0] count;
	} q_stat_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		if (v < 4'd10)
			return 8'h30 + {4'd0, v};
		else
			return 8'h37 + {4'd0, v};
	endfunction

endpackage

`default_nettype wire

/* sv/intel_hex_record_writer.sv */
// Top level of the Intel HEX record writer: front, job queue and back part.
// Depends on ihexw_pkg, ihexw_front, ihexw_queue and ihexw_back.
//
// Each input item is one data byte with its address, the bytes left in its
// segment and segment-start and file-end flags; the block returns the Intel
// HEX text that the byte causes, one ASCII character per output item, with
// last_char set on the final character for that byte. The output delivers one
// character per cycle while out_stall is low. An item causes 2 characters
// inside a record, 5 when it closes a record, 9 more when it opens one, 16 more
// for an extended linear address record and 12 more for the end-of-file
// record, from 2 up to 42. The input is taken every cycle while the four-entry
// job queue has room, so short bursts are absorbed and the sustained rate is
// set by the character output. record_length may be written only while the
// block is idle; a value of 0 acts as 1.
`default_nettype none

module intel_hex_record_writer
	import ihexw_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire in_item_t in_item,
	output logic out_valid,
	input wire logic out_stall,
	output out_item_t out_item,
	input wire logic cfg_we,
	input wire logic [7:0] cfg_wdata
);

	logic push, pop;
	job_t wr_job, rd_job;
	q_stat_t q_stat;

	ihexw_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_item(in_item),
		.in_stall(in_stall),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.q_full(q_stat.full),
		.push(push),
		.job(wr_job)
	);

	ihexw_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_job(wr_job),
		.pop(pop),
		.rd_job(rd_job),
		.stat(q_stat)
	);

	ihexw_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job(rd_job),
		.q_stat(q_stat),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

`ifndef ASSERT_OFF
	// No character may appear without a job behind it.
	a_no_orphan_char: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && q_stat.empty |=> !out_valid)
		else $error("character sent with no job queued");

	// Retiring a job always leaves its final character in the output register.
	a_pop_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid && out_item.last_char)
		else $error("job retired without a final character");

	// An accepted item without a retirement grows the queue by one.
	a_queue_grows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !pop |=> q_stat.count == $past(q_stat.count) + 1'b1)
		else $error("queue count lost an accepted item");
`endif

endmodule

`default_nettype wire

/* sv/ihexw_front.sv */
// Front part: holds record_length and the record state, classifies each item
// into a job for the queue. Depends on ihexw_pkg.
`default_nettype none

module ihexw_front
	import ihexw_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire in_item_t in_item,
	output logic in_stall,
	input wire logic cfg_we,
	input wire logic [7:0] cfg_wdata,
	input wire logic q_full,
	output logic push,
	output job_t job
);

	logic [7:0] rec_len_q;
	logic [7:0] bytes_q;
	logic [7:0] cur_len_q;
	logic [7:0] csum_q;
	logic need_addr_q;

	logic [31:0] addr;
	logic [15:0] lo16;
	logic [7:0] rl_eff, left_eff, len1, len;
	logic [16:0] to_bound;
	logic [7:0] b_eff, cs_eff, cl_eff, cl_new, cs_base, cs_new, b_new;
	logic na_eff, na_after, open, do_addr, do_close;

	assign in_stall = q_full;
	assign push = in_valid && !q_full;

	always_comb begin
		addr = in_item.byte_address & ADDR_MASK;
		lo16 = addr[15:0];
		rl_eff = (rec_len_q == 8'd0) ? 8'd1 : rec_len_q;
		left_eff = (in_item.bytes_left == 32'd0) ? 8'd1 : in_item.bytes_left[7:0];
		if ((in_item.bytes_left[31:8] == 24'd0) && (left_eff < rl_eff))
			len1 = left_eff;
		else
			len1 = rl_eff;
		to_bound = 17'h10000 - {1'b0, lo16};
		len = (to_bound < {9'd0, len1}) ? to_bound[7:0] : len1;

		// A segment start drops whatever record was open.
		b_eff = in_item.segment_start ? 8'd0 : bytes_q;
		cs_eff = in_item.segment_start ? 8'd0 : csum_q;
		cl_eff = in_item.segment_start ? 8'd0 : cur_len_q;
		na_eff = in_item.segment_start | need_addr_q;

		open = (b_eff == 8'd0);
		do_addr = open && na_eff;
		cl_new = open ? len : cl_eff;
		cs_base = open ? (len + lo16[15:8] + lo16[7:0]) : cs_eff;
		cs_new = cs_base + in_item.data_byte;
		b_new = b_eff + 8'd1;
		na_after = (lo16 == LO16_LAST) ? 1'b1 : (do_addr ? 1'b0 : na_eff);
		// The end of the image always closes the record, full or not.
		do_close = (b_new >= cl_new) || in_item.file_end;

		job.do_addr = do_addr;
		job.addr_hi = addr[31:24];
		job.addr_mid = addr[23:16];
		job.addr_sum = 8'd0 - (ADDR_REC_LEN + TYPE_ELA + addr[31:24] + addr[23:16]);
		job.do_open = open;
		job.rec_len = len;
		job.lo_hi = lo16[15:8];
		job.lo_lo = lo16[7:0];
		job.data = in_item.data_byte;
		job.do_close = do_close;
		job.close_sum = 8'd0 - cs_new;
		job.do_eof = in_item.file_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_len_q <= RECLEN_RESET;
			bytes_q <= 8'd0;
			cur_len_q <= 8'd0;
			csum_q <= 8'd0;
			need_addr_q <= 1'b1;
		end else begin
			if (cfg_we)
				rec_len_q <= cfg_wdata;
			if (push) begin
				if (in_item.file_end) begin
					bytes_q <= 8'd0;
					cur_len_q <= 8'd0;
					csum_q <= 8'd0;
					need_addr_q <= 1'b1;
				end else if (do_close) begin
					bytes_q <= 8'd0;
					cur_len_q <= 8'd0;
					csum_q <= 8'd0;
					need_addr_q <= na_after;
				end else begin
					bytes_q <= b_new;
					cur_len_q <= cl_new;
					csum_q <= cs_new;
					need_addr_q <= na_after;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* sv/ihexw_queue.sv */
// Short job queue between the front and back parts.
// Depends on ihexw_pkg for the job type and depth.
`default_nettype none

module ihexw_queue
	import ihexw_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire job_t wr_job,
	input wire logic pop,
	output job_t rd_job,
	output q_stat_t stat
);

	job_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign rd_job = mem_q[rd_ptr_q];
	assign stat.full = (count_q == QCNT_W'(QDEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.count = count_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

`default_nettype wire

/* sv/ihexw_back.sv */
// Back part: walks the head job of the queue and sends its text one character
// per cycle when not stalled, through an output register. Depends on ihexw_pkg.
`default_nettype none

module ihexw_back
	import ihexw_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire job_t job,
	input wire q_stat_t q_stat,
	output logic pop,
	output logic out_valid,
	input wire logic out_stall,
	output out_item_t out_item
);

	typedef enum logic [2:0] {
		P_ADDR,
		P_OPEN,
		P_DATA,
		P_CLOSE,
		P_EOF
	} phase_t;

	localparam logic [3:0] LAST_ADDR = 4'd15;
	localparam logic [3:0] LAST_OPEN = 4'd8;
	localparam logic [3:0] LAST_DATA = 4'd1;
	localparam logic [3:0] LAST_CLOSE = 4'd2;
	localparam logic [3:0] LAST_EOF = 4'd11;

	phase_t phase_q, phase, next_phase;
	logic [3:0] idx_q, last_idx;
	logic out_valid_q;
	out_item_t out_item_q;
	logic load, at_end, job_done;
	logic [7:0] ch;

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;
	assign load = !q_stat.empty && (!out_valid_q || !out_stall);
	assign pop = load && job_done;

	always_comb begin
		// A fresh job starts at the first part of text that it actually has.
		phase = phase_q;
		if (phase == P_ADDR && !job.do_addr)
			phase = P_OPEN;
		if (phase == P_OPEN && !job.do_open)
			phase = P_DATA;

		ch = CH_NL;
		last_idx = LAST_DATA;
		next_phase = P_ADDR;
		job_done = 1'b0;
		unique case (phase)
			P_ADDR: begin
				last_idx = LAST_ADDR;
				next_phase = P_OPEN;
				unique case (idx_q)
					4'd0: ch = CH_COLON;
					4'd1: ch = hex_digit(ADDR_REC_LEN[7:4]);
					4'd2: ch = hex_digit(ADDR_REC_LEN[3:0]);
					4'd7: ch = hex_digit(TYPE_ELA[7:4]);
					4'd8: ch = hex_digit(TYPE_ELA[3:0]);
					4'd9: ch = hex_digit(job.addr_hi[7:4]);
					4'd10: ch = hex_digit(job.addr_hi[3:0]);
					4'd11: ch = hex_digit(job.addr_mid[7:4]);
					4'd12: ch = hex_digit(job.addr_mid[3:0]);
					4'd13: ch = hex_digit(job.addr_sum[7:4]);
					4'd14: ch = hex_digit(job.addr_sum[3:0]);
					4'd15: ch = CH_NL;
					default: ch = hex_digit(4'd0);
				endcase
			end
			P_OPEN: begin
				last_idx = LAST_OPEN;
				next_phase = P_DATA;
				unique case (idx_q)
					4'd0: ch = CH_COLON;
					4'd1: ch = hex_digit(job.rec_len[7:4]);
					4'd2: ch = hex_digit(job.rec_len[3:0]);
					4'd3: ch = hex_digit(job.lo_hi[7:4]);
					4'd4: ch = hex_digit(job.lo_hi[3:0]);
					4'd5: ch = hex_digit(job.lo_lo[7:4]);
					4'd6: ch = hex_digit(job.lo_lo[3:0]);
					default: ch = hex_digit(4'd0);
				endcase
			end
			P_DATA: begin
				last_idx = LAST_DATA;
				ch = idx_q[0] ? hex_digit(job.data[3:0]) : hex_digit(job.data[7:4]);
				if (job.do_close)
					next_phase = P_CLOSE;
				else if (job.do_eof)
					next_phase = P_EOF;
				else
					job_done = at_end;
			end
			P_CLOSE: begin
				last_idx = LAST_CLOSE;
				unique case (idx_q)
					4'd0: ch = hex_digit(job.close_sum[7:4]);
					4'd1: ch = hex_digit(job.close_sum[3:0]);
					default: ch = CH_NL;
				endcase
				if (job.do_eof)
					next_phase = P_EOF;
				else
					job_done = at_end;
			end
			P_EOF: begin
				last_idx = LAST_EOF;
				job_done = at_end;
				unique case (idx_q)
					4'd0: ch = CH_COLON;
					4'd8: ch = hex_digit(4'd1);
					4'd9, 4'd10: ch = hex_digit(4'hF);
					4'd11: ch = CH_NL;
					default: ch = hex_digit(4'd0);
				endcase
			end
			default: begin
				ch = CH_NL;
			end
		endcase
	end

	assign at_end = (idx_q == last_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_ADDR;
			idx_q <= 4'd0;
			out_valid_q <= 1'b0;
			out_item_q <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				out_item_q.text_char <= ch;
				out_item_q.last_char <= job_done;
				if (job_done) begin
					phase_q <= P_ADDR;
					idx_q <= 4'd0;
				end else if (at_end) begin
					phase_q <= next_phase;
					idx_q <= 4'd0;
				end else begin
					phase_q <= phase;
					idx_q <= idx_q + 4'd1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire
